// ===== design/esrsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esrsd_pkg
// Shared types and constants for the escape-run sample decoder.
// ----------------------------------------------------------------------------
package esrsd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned COUNT_W  = 16;

  // escape byte (-128) that introduces a run of 16-bit samples
  localparam logic [BYTE_W-1:0]  ESCAPE_BYTE         = 8'h80;
  localparam logic [COUNT_W-1:0] BLOCK_SAMPLES_RESET = 16'd1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       block_end;
    logic                       count_error;
  } res_t;

endpackage

// ===== design/esrsd_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esrsd_core
// Decode state machine: updates phase and counters on every accepted byte
// and forms the sample that the byte completes, if any.
// ----------------------------------------------------------------------------
module esrsd_core
  import esrsd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [BYTE_W-1:0]  data_byte,
  input  logic [COUNT_W-1:0] block_samples,
  output logic               res_valid,
  output res_t               res
);

  typedef enum logic [1:0] {
    PH_OPEN,
    PH_SAMPLE,
    PH_ESCCNT,
    PH_LOW
  } phase_t;

  phase_t              phase_r,        phase_nxt;
  logic [BYTE_W-1:0]   run_left_r,     run_left_nxt;
  logic [BYTE_W-1:0]   high_part_r,    high_part_nxt;
  logic [COUNT_W-1:0]  samples_done_r, samples_done_nxt;
  logic                error_seen_r,   error_seen_nxt;

  logic                emit;
  logic                last;
  logic [COUNT_W-1:0]  limit;
  logic [COUNT_W:0]    done_plus1;
  logic [SAMPLE_W-1:0] value;

  // a block size of zero acts as one
  assign limit      = (block_samples == '0) ? COUNT_W'(1) : block_samples;
  assign done_plus1 = {1'b0, samples_done_r} + (COUNT_W+1)'(1);
  assign last       = (done_plus1 >= {1'b0, limit});

  always_comb begin
    phase_nxt        = phase_r;
    run_left_nxt     = run_left_r;
    high_part_nxt    = high_part_r;
    samples_done_nxt = samples_done_r;
    error_seen_nxt   = error_seen_r;
    emit             = 1'b0;
    value            = '0;

    case (phase_r)
      PH_SAMPLE: begin
        if (run_left_r != '0) begin
          high_part_nxt = data_byte;
          phase_nxt     = PH_LOW;
        end else if (data_byte == ESCAPE_BYTE) begin
          phase_nxt = PH_ESCCNT;
        end else begin
          emit  = 1'b1;
          value = {{(SAMPLE_W-BYTE_W){data_byte[BYTE_W-1]}}, data_byte};
        end
      end
      PH_ESCCNT: begin
        // zero-length escape run is flagged and decoded as a run of one
        if (data_byte == '0) begin
          error_seen_nxt = 1'b1;
          run_left_nxt   = BYTE_W'(1);
        end else begin
          run_left_nxt = data_byte;
        end
        phase_nxt = PH_SAMPLE;
      end
      PH_LOW: begin
        run_left_nxt = run_left_r - BYTE_W'(1);
        phase_nxt    = PH_SAMPLE;
        emit         = 1'b1;
        value        = {high_part_r, data_byte};
      end
      default: begin
        run_left_nxt = data_byte;
        phase_nxt    = PH_SAMPLE;
      end
    endcase

    if (emit) begin
      error_seen_nxt = 1'b0;
      if (last) begin
        // rest of any open run is dropped at block end
        phase_nxt        = PH_OPEN;
        run_left_nxt     = '0;
        samples_done_nxt = '0;
      end else begin
        samples_done_nxt = done_plus1[COUNT_W-1:0];
      end
    end
  end

  assign res_valid       = emit;
  assign res.sample      = value;
  assign res.block_end   = last;
  assign res.count_error = error_seen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_OPEN;
      run_left_r     <= '0;
      high_part_r    <= '0;
      samples_done_r <= '0;
      error_seen_r   <= 1'b0;
    end else if (accept) begin
      phase_r        <= phase_nxt;
      run_left_r     <= run_left_nxt;
      high_part_r    <= high_part_nxt;
      samples_done_r <= samples_done_nxt;
      error_seen_r   <= error_seen_nxt;
    end
  end

endmodule

// ===== design/escape_run_sample_decoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_run_sample_decoder_top
// Byte-stream decoder for escape-coded blocks of 16-bit samples.
// ----------------------------------------------------------------------------
// Input channel in_*: one compressed byte per beat. Output channel out_*:
// one decoded sample per beat, tlast marks the last sample of a block and
// tuser flags a zero-length escape run seen before this sample.
// Opening count, escape byte, escape count and high byte give no beat.
// The block length comes from cfg_wr_data, written whenever cfg_wr_en is
// high; change it only while the decoder is idle.
// Throughput is one byte per cycle while in_tready is high. The sample a
// byte completes is registered on out_*, or in the skid buffer if out_* is
// stalled; the decode state machine updates in the same cycle the byte is accepted.
// The output register is backed by a one-beat skid buffer, so in_tready
// stays high while a sample waits on out_*; it drops only once both the
// output register and the skid buffer hold samples, and comes back the
// cycle after the receiver takes one.
// Reset (rst_n low, synchronous) empties both and returns the decoder to
// expecting the opening run length, with a block length of one.
// ----------------------------------------------------------------------------
module escape_run_sample_decoder_top
  import esrsd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // in_tdata: [7:0] data_byte
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [BYTE_W-1:0]   in_tdata,
  // out_tdata: [15:0] sample
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [SAMPLE_W-1:0] out_tdata,
  output logic                out_tlast,
  // out_tuser: [0] count_error
  output logic                out_tuser,
  input  logic                cfg_wr_en,
  input  logic [COUNT_W-1:0]  cfg_wr_data
);

  logic [COUNT_W-1:0] block_samples_r;
  logic               accept;
  logic               res_valid;
  res_t               res;
  res_t               out_r;
  res_t               skid_r;
  logic               out_valid_r;
  logic               skid_valid_r;

  assign in_tready = !skid_valid_r;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_samples_r <= BLOCK_SAMPLES_RESET;
    end else if (cfg_wr_en) begin
      block_samples_r <= cfg_wr_data;
    end
  end

  esrsd_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .data_byte     (in_tdata),
    .block_samples (block_samples_r),
    .res_valid     (res_valid),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept && res_valid;
      end
    end else if (accept && res_valid) begin
      // output stalled: park the new beat in the skid buffer
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (accept && res_valid) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r.sample;
  assign out_tlast  = out_r.block_end;
  assign out_tuser  = out_r.count_error;

endmodule

// ===== design/esrsd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esrsd_checker
// Port-level checks for the escape-run sample decoder, bound to the top.
// ----------------------------------------------------------------------------
module esrsd_checker
  import esrsd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tready,
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic [SAMPLE_W-1:0] out_tdata,
  input  logic                out_tlast,
  input  logic                out_tuser
);

  // a held output beat stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out beat dropped while stalled");

  // a held output beat keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))
    else $error("out payload changed while stalled");

  // reset empties the output side
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("output not empty after reset");

  // input backpressure only when a sample is waiting downstream
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("in_tready low with no pending out beat");

  // a full skid buffer drains into the output register when it frees up
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready && out_tready |=> out_tvalid && in_tready)
    else $error("skid buffer did not drain");

endmodule

bind escape_run_sample_decoder_top esrsd_checker u_esrsd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

// ===== test/tb_escape_run_sample_decoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_escape_run_sample_decoder_top
// Self-checking bench for the escape-run sample decoder: bytes go in on a
// stream port with random bursts and gaps, decoded samples are compared
// beat by beat against an in-bench decoder model while the sink stalls.
// ----------------------------------------------------------------------------
module tb_escape_run_sample_decoder_top
  import esrsd_pkg::*;
();

  localparam int CYCLE_LIMIT  = 300000;
  localparam int SETTLE_WAIT  = 4;
  localparam int FINAL_WAIT   = 10;

  typedef enum logic [2:0] {
    ST_OPEN_COUNT = 3'd0,
    ST_SAMPLE     = 3'd1,
    ST_ESC_COUNT  = 3'd2,
    ST_LOW_BYTE   = 3'd3
  } dec_state_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [BYTE_W-1:0]   in_tdata;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [SAMPLE_W-1:0] out_tdata;
  logic                out_tlast;
  logic                out_tuser;
  logic                cfg_wr_en;
  logic [COUNT_W-1:0]  cfg_wr_data;

  // decoder model state
  dec_state_t          m_state;
  logic [7:0]          m_run_left;
  logic [7:0]          m_high;
  logic [15:0]         m_done;
  logic                m_err;
  logic [COUNT_W-1:0]  m_block_len;

  res_t                expected_samples[$];

  int errors       = 0;
  int cycle_count  = 0;
  int bytes_sent   = 0;
  int n_samples    = 0;
  int n_block_ends = 0;
  int n_zero_esc   = 0;
  int burst_left   = 0;
  bit tx_gaps_on   = 1'b1;

  // sink stall pattern
  int rx_mode  = 0;
  int rx_span  = 0;
  int rx_stall = 0;

  escape_run_sample_decoder_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void push_sample(input logic [15:0] value);
    logic [16:0] lim;
    logic        last;
    res_t        r;
    lim  = (m_block_len == '0) ? 17'd1 : {1'b0, m_block_len};
    last = (({1'b0, m_done} + 17'd1) >= lim);
    r.sample      = value;
    r.block_end   = last;
    r.count_error = m_err;
    expected_samples.push_back(r);
    n_samples++;
    if (last) n_block_ends++;
    m_err = 1'b0;
    if (last) begin
      m_state    = ST_OPEN_COUNT;
      m_run_left = '0;
      m_done     = '0;
    end else begin
      m_done = m_done + 16'd1;
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    case (m_state)
      ST_SAMPLE: begin
        if (m_run_left != 8'd0) begin
          m_high  = b;
          m_state = ST_LOW_BYTE;
        end else if (b == ESCAPE_BYTE) begin
          m_state = ST_ESC_COUNT;
        end else begin
          push_sample({{8{b[7]}}, b});
        end
      end
      ST_ESC_COUNT: begin
        // zero-length escape run counts as one and is flagged
        if (b == 8'd0) begin
          m_err      = 1'b1;
          m_run_left = 8'd1;
          n_zero_esc++;
        end else begin
          m_run_left = b;
        end
        m_state = ST_SAMPLE;
      end
      ST_LOW_BYTE: begin
        m_run_left = m_run_left - 8'd1;
        m_state    = ST_SAMPLE;
        push_sample({m_high, b});
      end
      default: begin
        m_run_left = b;
        m_state    = ST_SAMPLE;
      end
    endcase
  endfunction

  function automatic void check_sample();
    res_t want;
    if (expected_samples.size() == 0) begin
      $error("output beat with no expected sample: sample %h last %b user %b",
             out_tdata, out_tlast, out_tuser);
      errors++;
    end else begin
      want = expected_samples.pop_front();
      if (out_tdata !== want.sample) begin
        $error("sample: expected %h, actual %h", want.sample, out_tdata);
        errors++;
      end
      if (out_tlast !== want.block_end) begin
        $error("block_end: expected %b, actual %b", want.block_end, out_tlast);
        errors++;
      end
      if (out_tuser !== want.count_error) begin
        $error("count_error: expected %b, actual %b", want.count_error, out_tuser);
        errors++;
      end
    end
  endfunction

  // monitor: checks output beats, tracks config writes, predicts input beats
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d samples outstanding",
               cycle_count, expected_samples.size());
      $display("== FAIL ==");
      $finish;
    end else if (!rst_n) begin
      m_state     = ST_OPEN_COUNT;
      m_run_left  = '0;
      m_high      = '0;
      m_done      = '0;
      m_err       = 1'b0;
      m_block_len = BLOCK_SAMPLES_RESET;
    end else begin
      if (out_tvalid && out_tready) check_sample();
      if (cfg_wr_en) m_block_len = cfg_wr_data;
      if (in_tvalid && in_tready) decode_byte(in_tdata);
    end
  end

  // sink: always ready, coin-flip ready, or mostly ready with long stalls
  always @(posedge clk) begin
    if (rx_span == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_span = $urandom_range(20, 150);
    end
    rx_span--;
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      default: begin
        if (rx_stall > 0) begin
          rx_stall--;
          out_tready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
          rx_stall = $urandom_range(1, 20);
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
        end
      end
    endcase
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (tx_gaps_on && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 8);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_pair(input logic [15:0] value);
    send_byte(value[15:8]);
    send_byte(value[7:0]);
  endtask

  // stop sending and let every expected sample come out
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    // wait so the monitor has predicted the last accepted byte
    @(posedge clk);
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_block_len(input logic [COUNT_W-1:0] value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == ESCAPE_BYTE);
    return b;
  endfunction

  // one block of n samples with random content, at times led by a stray random byte
  task automatic send_block(input int n);
    int k, r, c, eff, m, i;
    if ($urandom_range(0, 11) == 0) send_byte(8'($urandom_range(0, 255)));
    case ($urandom_range(0, 9))
      0, 1, 2: k = 0;
      9:       k = $urandom_range(0, 255);
      default: k = $urandom_range(1, 5);
    endcase
    send_byte(k[7:0]);
    m = (k < n) ? k : n;
    for (i = 0; i < m; i++) send_pair(16'($urandom_range(0, 65535)));
    r = n - m;
    while (r > 0) begin
      if ($urandom_range(0, 4) < 3) begin
        send_byte(plain_byte());
        r--;
      end else begin
        case ($urandom_range(0, 15))
          0, 1:    c = 0;
          2:       c = $urandom_range(0, 255);
          default: c = $urandom_range(1, 6);
        endcase
        eff = (c == 0) ? 1 : c;
        send_byte(ESCAPE_BYTE);
        send_byte(c[7:0]);
        m = (eff < r) ? eff : r;
        for (i = 0; i < m; i++) send_pair(16'($urandom_range(0, 65535)));
        r -= m;
      end
    end
  endtask

  task automatic test_plain_and_escape();
    write_block_len(16'd4);
    // opening run of zero, then four plain 8-bit samples
    send_byte(8'h00);
    send_byte(8'h7f);
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h01);
    // one-sample opening run, a zero-length escape, a normal escape
    send_byte(8'h01);
    send_pair(16'h8000);
    send_byte(ESCAPE_BYTE);
    send_byte(8'h00);
    send_pair(16'h7fff);
    send_byte(8'h81);
    send_byte(ESCAPE_BYTE);
    send_byte(8'h02);
    send_pair(16'h1234);
  endtask

  task automatic test_long_counts();
    // full-length runs cut short by the end of the block
    write_block_len(16'd2);
    send_byte(8'hff);
    send_pair(16'h0000);
    send_pair(16'hffff);
    send_byte(8'h00);
    send_byte(ESCAPE_BYTE);
    send_byte(8'hff);
    send_pair(16'h55aa);
    send_byte(8'h01);
  endtask

  task automatic test_block_len_edges();
    // block length zero acts as one
    write_block_len(16'd0);
    send_byte(8'h00);
    send_byte(8'h05);
    send_byte(8'h01);
    send_pair(16'hc3a5);
    // shrink the block length partway through a block
    write_block_len(16'd10);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'h02);
    send_byte(8'h03);
    write_block_len(16'd2);
    send_byte(8'h04);
  endtask

  task automatic test_random_blocks();
    int p, target, n;
    logic [COUNT_W-1:0] len;
    bit paused;
    paused = 1'b0;
    for (p = 0; p < 7; p++) begin
      case (p)
        0:       len = 16'd1;
        1:       len = 16'd2;
        2:       len = 16'd7;
        3:       len = 16'($urandom_range(3, 20));
        4:       len = 16'hffff;
        5:       len = 16'd0;
        default: len = 16'($urandom_range(1, 12));
      endcase
      tx_gaps_on = (p != 1);
      write_block_len(len);
      target = bytes_sent + 45;
      while (bytes_sent < target) begin
        if (len == '0)     n = 1;
        else if (len > 40) n = $urandom_range(5, 40);
        else               n = len;
        send_block(n);
        if (p == 3 && !paused && bytes_sent >= target - 30) begin
          wait_drained();
          paused = 1'b1;
        end
      end
    end
    tx_gaps_on = 1'b1;
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_plain_and_escape();
    test_long_counts();
    test_block_len_edges();
    test_random_blocks();

    wait_drained();
    repeat (FINAL_WAIT) @(posedge clk);
    if (expected_samples.size() != 0) begin
      $error("%0d expected samples never arrived", expected_samples.size());
      errors++;
    end
    $display("sent %0d bytes, checked %0d samples over %0d block ends, %0d zero escapes",
             bytes_sent, n_samples, n_block_ends, n_zero_esc);
    $display("block lengths 0, 1, 2, small and 65535; run counts from 0 to 255");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/esrsd_pkg.sv
design/esrsd_core.sv
design/escape_run_sample_decoder_top.sv
design/esrsd_checker.sv
test/tb_escape_run_sample_decoder_top.sv
